### sv/ale_pkg.sv
// Shared types and constants for the array list engine.
// Holds request and response structs, function and status codes, and
// the command and status bundles between controller and datapath.
`default_nettype none

package ale_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int LEN_W = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		FN_INS_END   = 3'd0,
		FN_INS_FRONT = 3'd1,
		FN_INS_POS   = 3'd2,
		FN_DEL_FIRST = 3'd3,
		FN_DEL_POS   = 3'd4,
		FN_DEL_ALL   = 3'd5,
		FN_DUMP      = 3'd6
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_BADPOS  = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] value;
		logic [3:0]         position;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [4:0]         count;
		logic signed [31:0] data_out;
		logic               last;
		logic [4:0]         removed;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic exec_single;
		logic clr_idx;
		logic step;
		logic del_idx;
		logic emit_scan;
		logic emit_dump;
		logic emit_empty;
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       len_zero;
		logic       scan_end;
		logic       match;
		logic       found;
		logic       dump_last;
		logic       out_free;
	} sts_t;

endpackage

`default_nettype wire

### sv/array_list_engine_core.sv
// Array list engine top level: a signed 32-bit list of 16 entries.
// Insert, delete at position and empty dump: loaded in idle, answered by the execute state.
// Match deletes walk the list one entry a cycle.
// A dump gives one response per cycle unless stalled; a new request is taken when the walk ends.
// Reset clears the element count, the controller and the response valid; entries are not cleared.
`default_nettype none

module array_list_engine_core
	import ale_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	cmd_t cmd;
	sts_t sts;

	ale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ale_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

### sv/ale_dp.sv
// Datapath of the array list engine: entry cells, element count, walk index,
// removal counter and the response register. Depends on ale_pkg.
`default_nettype none

module ale_dp
	import ale_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire req_t req,
	input  wire cmd_t cmd,
	output sts_t      sts,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	req_t               req_q;
	logic signed [31:0] ent_q [DEPTH];
	logic signed [31:0] below_w [DEPTH];
	logic signed [31:0] above_w [DEPTH];
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   idx_q;
	logic [LEN_W-1:0]   rem_q;
	logic               out_valid_q;
	rsp_t               out_q;

	logic               full;
	logic               pos_ok;
	logic               s_ins;
	logic               s_del;
	logic [IDX_W-1:0]   s_ins_at;
	logic [1:0]         s_status;
	logic               ins_en;
	logic               del_en;
	logic [IDX_W-1:0]   del_at;
	logic [LEN_W-1:0]   len_nx;
	logic signed [31:0] cur_w;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			if (g == 0) begin : g_lo
				assign below_w[g] = req_q.value;
			end else begin : g_mid
				assign below_w[g] = ent_q[g-1];
			end
			if (g == DEPTH - 1) begin : g_hi
				assign above_w[g] = ent_q[g];
			end else begin : g_up
				assign above_w[g] = ent_q[g+1];
			end
		end
	endgenerate

	assign full   = (len_q >= LEN_W'(DEPTH));
	assign pos_ok = (LEN_W'(req_q.position) < len_q);
	assign cur_w  = ent_q[idx_q[IDX_W-1:0]];

	always_comb begin
		s_ins    = 1'b0;
		s_del    = 1'b0;
		s_ins_at = '0;
		s_status = ST_DONE;
		case (req_q.func)
			FN_INS_END: begin
				if (full) s_status = ST_FULL;
				else begin
					s_ins    = 1'b1;
					s_ins_at = len_q[IDX_W-1:0];
				end
			end
			FN_INS_FRONT: begin
				if (full) s_status = ST_FULL;
				else s_ins = 1'b1;
			end
			FN_INS_POS: begin
				if (full) s_status = ST_FULL;
				else if (!pos_ok) s_status = ST_BADPOS;
				else begin
					s_ins    = 1'b1;
					s_ins_at = IDX_W'(req_q.position);
				end
			end
			FN_DEL_POS: begin
				if (len_q == '0) s_status = ST_MISSING;
				else if (!pos_ok) s_status = ST_BADPOS;
				else s_del = 1'b1;
			end
			default: begin
				s_status = ST_DONE;
			end
		endcase
	end

	assign ins_en = cmd.exec_single && s_ins;
	assign del_en = (cmd.exec_single && s_del) || cmd.del_idx;
	assign del_at = cmd.del_idx ? idx_q[IDX_W-1:0] : IDX_W'(req_q.position);
	assign len_nx = len_q + LEN_W'(ins_en) - LEN_W'(del_en);

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		for (int j = 0; j < DEPTH; j++) begin
			if (ins_en) begin
				if (IDX_W'(j) > s_ins_at) ent_q[j] <= below_w[j];
				else if (IDX_W'(j) == s_ins_at) ent_q[j] <= req_q.value;
			end else if (del_en) begin
				if (IDX_W'(j) >= del_at) ent_q[j] <= above_w[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			idx_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			len_q <= len_nx;
			if (cmd.clr_idx) begin
				idx_q <= '0;
				rem_q <= '0;
			end else if (cmd.step) begin
				idx_q <= idx_q + 1'b1;
			end else if (cmd.del_idx) begin
				rem_q <= rem_q + 1'b1;
			end
			if (cmd.exec_single || cmd.emit_scan || cmd.emit_dump || cmd.emit_empty) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec_single) begin
			out_q.status   <= s_status;
			out_q.count    <= 5'(len_nx);
			out_q.data_out <= '0;
			out_q.last     <= 1'b1;
			out_q.removed  <= {4'd0, s_del};
		end else if (cmd.emit_scan) begin
			out_q.status   <= (rem_q != '0) ? ST_DONE : ST_MISSING;
			out_q.count    <= 5'(len_q);
			out_q.data_out <= '0;
			out_q.last     <= 1'b1;
			out_q.removed  <= 5'(rem_q);
		end else if (cmd.emit_dump) begin
			out_q.status   <= ST_DONE;
			out_q.count    <= 5'(len_q);
			out_q.data_out <= cur_w;
			out_q.last     <= sts.dump_last;
			out_q.removed  <= '0;
		end else if (cmd.emit_empty) begin
			out_q.status   <= ST_MISSING;
			out_q.count    <= 5'(len_q);
			out_q.data_out <= '0;
			out_q.last     <= 1'b1;
			out_q.removed  <= '0;
		end
	end

	assign sts.func      = req_q.func;
	assign sts.len_zero  = (len_q == '0);
	assign sts.scan_end  = (idx_q >= len_q);
	assign sts.match     = (cur_w == req_q.value);
	assign sts.found     = (rem_q != '0);
	assign sts.dump_last = ((idx_q + 1'b1) == len_q);
	assign sts.out_free  = !out_valid_q || rsp_ready;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(DEPTH))
		else $error("element count exceeds storage depth");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec_single || cmd.emit_scan || cmd.emit_dump || cmd.emit_empty)
		|-> (!out_valid_q || rsp_ready))
		else $error("response written while the previous one is still pending");

	a_del_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del_idx |=> (len_q == $past(len_q) - 1'b1))
		else $error("match removal did not shrink the list");

endmodule

`default_nettype wire

### sv/ale_ctrl.sv
// Controller of the array list engine: sequences request load, single-step
// operations, the match walk and the dump walk. Depends on ale_pkg.
`default_nettype none

module ale_ctrl
	import ale_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_FIN,
		S_DUMP
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.func == FN_DEL_FIRST || sts.func == FN_DEL_ALL) begin
					cmd.clr_idx = 1'b1;
					state_nx    = S_SCAN;
				end else if (sts.func == FN_DUMP) begin
					if (!sts.len_zero) begin
						cmd.clr_idx = 1'b1;
						state_nx    = S_DUMP;
					end else if (sts.out_free) begin
						cmd.emit_empty = 1'b1;
						state_nx       = S_IDLE;
					end
				end else if (sts.out_free) begin
					cmd.exec_single = 1'b1;
					state_nx        = S_IDLE;
				end
			end
			S_SCAN: begin
				if (sts.scan_end || (sts.func == FN_DEL_FIRST && sts.found)) begin
					state_nx = S_FIN;
				end else if (sts.match) begin
					cmd.del_idx = 1'b1;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.emit_scan = 1'b1;
					state_nx      = S_IDLE;
				end
			end
			S_DUMP: begin
				if (sts.out_free) begin
					cmd.emit_dump = 1'b1;
					cmd.step      = 1'b1;
					if (sts.dump_last) state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	a_dump_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_dump && sts.dump_last) |=> req_ready)
		else $error("dump did not return to idle after its final element");

	a_scan_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !(cmd.emit_scan || cmd.emit_dump || cmd.exec_single))
		else $error("response issued during the match walk");

	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_EXEC))
		else $error("loaded request was not executed");

endmodule

`default_nettype wire
